// ----- rtl/core/sws_pkg.sv -----
package sws_pkg;

    localparam int SEQ_W  = 32;
    localparam int LEN_W  = 11;
    localparam int CMD_W  = 2;
    localparam int ACT_W  = 3;
    localparam int SLOT_W = 3;
    localparam int OUTS_W = 4;
    localparam int TICK_W = 16;
    localparam int LIM_W  = 16;

    localparam logic [TICK_W-1:0] RETRY_RESET = 16'd120;

    localparam logic [CMD_W-1:0] CMD_SEND = 2'd0;
    localparam logic [CMD_W-1:0] CMD_ACK  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = $clog2(Q_DEPTH);

    typedef enum logic [1:0] {
        OP_SEND,
        OP_ACK,
        OP_TICK
    } t_op;

    typedef enum logic [ACT_W-1:0] {
        ACT_TX      = 3'd0,
        ACT_RETX    = 3'd1,
        ACT_ACK_OK  = 3'd2,
        ACT_ACK_IGN = 3'd3,
        ACT_FULL    = 3'd4
    } t_action;

    typedef struct packed {
        t_op               op;
        logic [LEN_W-1:0]  len;
        logic [SEQ_W-1:0]  ack_no;
    } t_qentry;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SEND,
        ST_ACK_CHK,
        ST_ACK_RD,
        ST_ACK_CMP,
        ST_ACK_IGN,
        ST_TICK,
        ST_RETX_RD,
        ST_RETX_OUT
    } t_state;

endpackage

// ----- rtl/core/sliding_window_sender.sv -----
// Per item: a send emits a transmit result, or a full result when the window is full;
// an ack reads and compares window entries from the head and emits an ok result on a match,
// else an ignore result, also when the window is empty or the ack is below base; plain tick, no result.
// Expiry: a tick that expires the timer retransmits every outstanding entry, head first.
// One item runs at a time, a stalled output holds it; a 2-entry queue keeps taking input until full.
// Reset (sync, active low): window, queue, seq numbers, timer, output valid cleared; timeout 120.
module sliding_window_sender
    import sws_pkg::*;
#(
    parameter int WINDOW_DEPTH = 8,
    parameter int MAX_SEG_LEN  = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [TICK_W-1:0]  i_cfg_wdata,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [CMD_W-1:0]   i_cmd,
    input  logic [LEN_W-1:0]   i_seg_len,
    input  logic [SEQ_W-1:0]   i_ack_no,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic [ACT_W-1:0]   o_action,
    output logic [SEQ_W-1:0]   o_seq_no,
    output logic [LEN_W-1:0]   o_seg_length,
    output logic [SLOT_W-1:0]  o_slot,
    output logic [OUTS_W-1:0]  o_outstanding,
    output logic               o_timer_on,
    output logic               o_last
);

    logic    q_push;
    logic    q_pop;
    logic    q_full;
    logic    q_empty;
    t_qentry q_in;
    t_qentry q_out;

    sws_front #(
        .MAX_SEG_LEN (MAX_SEG_LEN)
    ) u_front (
        .i_in_valid (i_in_valid),
        .i_cmd      (i_cmd),
        .i_seg_len  (i_seg_len),
        .i_ack_no   (i_ack_no),
        .i_q_full   (q_full),
        .o_in_ready (o_in_ready),
        .o_push     (q_push),
        .o_entry    (q_in)
    );

    sws_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (q_in),
        .i_pop   (q_pop),
        .o_entry (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    sws_back #(
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_q_empty     (q_empty),
        .i_q_entry     (q_out),
        .o_q_pop       (q_pop),
        .i_out_ready   (i_out_ready),
        .o_out_valid   (o_out_valid),
        .o_action      (o_action),
        .o_seq_no      (o_seq_no),
        .o_seg_length  (o_seg_length),
        .o_slot        (o_slot),
        .o_outstanding (o_outstanding),
        .o_timer_on    (o_timer_on),
        .o_last        (o_last)
    );

endmodule

// ----- rtl/core/sws_front.sv -----
module sws_front
    import sws_pkg::*;
#(
    parameter int MAX_SEG_LEN = 1024
) (
    input  logic              i_in_valid,
    input  logic [CMD_W-1:0]  i_cmd,
    input  logic [LEN_W-1:0]  i_seg_len,
    input  logic [SEQ_W-1:0]  i_ack_no,
    input  logic              i_q_full,
    output logic              o_in_ready,
    output logic              o_push,
    output t_qentry           o_entry
);

    localparam logic [LIM_W-1:0] MaxLen = LIM_W'(MAX_SEG_LEN);

    logic keep;

    always_comb begin
        o_entry.op     = OP_TICK;
        o_entry.len    = i_seg_len;
        o_entry.ack_no = i_ack_no;
        keep           = 1'b0;
        unique case (i_cmd)
            CMD_SEND: begin
                o_entry.op = OP_SEND;
                keep       = (i_seg_len != '0);
                if (LIM_W'(i_seg_len) > MaxLen) begin
                    o_entry.len = MaxLen[LEN_W-1:0];
                end
            end
            CMD_ACK: begin
                o_entry.op = OP_ACK;
                keep       = 1'b1;
            end
            CMD_TICK: begin
                o_entry.op = OP_TICK;
                keep       = 1'b1;
            end
            default: begin
                keep = 1'b0;
            end
        endcase
    end

    assign o_in_ready = !i_q_full;
    assign o_push     = i_in_valid && !i_q_full && keep;

endmodule

// ----- rtl/core/sws_queue.sv -----
module sws_queue
    import sws_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_qentry i_entry,
    input  logic    i_pop,
    output t_qentry o_entry,
    output logic    o_full,
    output logic    o_empty
);

    t_qentry              r_mem [Q_DEPTH];
    logic [Q_PTR_W-1:0]   r_wr_ptr;
    logic [Q_PTR_W-1:0]   r_rd_ptr;
    logic [Q_PTR_W:0]     r_count;

    assign o_full  = (r_count == (Q_PTR_W+1)'(Q_DEPTH));
    assign o_empty = (r_count == '0);
    assign o_entry = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_PTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_PTR_W'(1);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (Q_PTR_W+1)'(1);
                2'b01:   r_count <= r_count - (Q_PTR_W+1)'(1);
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

// ----- rtl/core/sws_back.sv -----
module sws_back
    import sws_pkg::*;
#(
    parameter int WINDOW_DEPTH = 8
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [TICK_W-1:0]  i_cfg_wdata,
    input  logic               i_q_empty,
    input  t_qentry            i_q_entry,
    output logic               o_q_pop,
    input  logic               i_out_ready,
    output logic               o_out_valid,
    output logic [ACT_W-1:0]   o_action,
    output logic [SEQ_W-1:0]   o_seq_no,
    output logic [LEN_W-1:0]   o_seg_length,
    output logic [SLOT_W-1:0]  o_slot,
    output logic [OUTS_W-1:0]  o_outstanding,
    output logic               o_timer_on,
    output logic               o_last
);

    localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
    localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
    localparam int SUM_W = IDX_W + CNT_W + 1;
    localparam logic [CNT_W-1:0] Depth = CNT_W'(WINDOW_DEPTH);

    function automatic logic [IDX_W-1:0] wrap_add(input logic [IDX_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [SUM_W-1:0] s;
        s = SUM_W'(a) + SUM_W'(b);
        if (s >= SUM_W'(WINDOW_DEPTH)) begin
            s = s - SUM_W'(WINDOW_DEPTH);
        end
        return s[IDX_W-1:0];
    endfunction

    function automatic logic [SLOT_W-1:0] to_slot(input logic [CNT_W-1:0] v);
        logic [SLOT_W+CNT_W-1:0] e;
        e = (SLOT_W+CNT_W)'(v);
        return e[SLOT_W-1:0];
    endfunction

    function automatic logic [OUTS_W-1:0] to_outs(input logic [CNT_W-1:0] v);
        logic [OUTS_W+CNT_W-1:0] e;
        e = (OUTS_W+CNT_W)'(v);
        return e[OUTS_W-1:0];
    endfunction

    logic [SEQ_W-1:0] r_seq_mem [WINDOW_DEPTH];
    logic [LEN_W-1:0] r_len_mem [WINDOW_DEPTH];
    logic [SEQ_W-1:0] r_rd_seq;
    logic [LEN_W-1:0] r_rd_len;

    t_state             r_state, n_state;
    t_qentry            r_cur, n_cur;
    logic [IDX_W-1:0]   r_head, n_head;
    logic [CNT_W-1:0]   r_occ, n_occ;
    logic [IDX_W-1:0]   r_idx, n_idx;
    logic [SEQ_W-1:0]   r_next_seq, n_next_seq;
    logic [SEQ_W-1:0]   r_base_seq, n_base_seq;
    logic [SEQ_W-1:0]   r_head_seq, n_head_seq;
    logic               r_timer_on, n_timer_on;
    logic [TICK_W-1:0]  r_timer_left, n_timer_left;
    logic [TICK_W-1:0]  r_retry;

    logic               r_out_valid;
    t_action            r_out_action;
    logic [SEQ_W-1:0]   r_out_seq;
    logic [LEN_W-1:0]   r_out_len;
    logic [SLOT_W-1:0]  r_out_slot;
    logic [OUTS_W-1:0]  r_out_outs;
    logic               r_out_timer;
    logic               r_out_last;

    logic               emit;
    t_action            e_action;
    logic [SEQ_W-1:0]   e_seq;
    logic [LEN_W-1:0]   e_len;
    logic [SLOT_W-1:0]  e_slot;
    logic [OUTS_W-1:0]  e_outs;
    logic               e_timer;
    logic               e_last;

    logic               wr_en;
    logic [IDX_W-1:0]   wr_addr;
    logic               rd_en;
    logic [IDX_W-1:0]   rd_addr;

    logic               out_free;
    logic               occ_full;
    logic [SUM_W-1:0]   idx_plus;
    logic               idx_last;
    logic               ack_hit;
    logic               ack_pre;
    logic               tick_expire;
    logic [CNT_W-1:0]   occ_keep;

    assign out_free    = !r_out_valid || i_out_ready;
    assign occ_full    = (r_occ == Depth);
    assign idx_plus    = SUM_W'(r_idx) + SUM_W'(1);
    assign idx_last    = (idx_plus == SUM_W'(r_occ));
    assign ack_hit     = ((r_rd_seq + SEQ_W'(r_rd_len)) == r_cur.ack_no);
    assign ack_pre     = (r_occ != '0) && (r_cur.ack_no >= r_base_seq);
    assign tick_expire = (r_timer_left <= TICK_W'(1));
    assign occ_keep    = r_occ - idx_plus[CNT_W-1:0];

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (!i_q_empty) begin
                    unique case (i_q_entry.op)
                        OP_SEND: n_state = ST_SEND;
                        OP_ACK:  n_state = ST_ACK_CHK;
                        OP_TICK: n_state = ST_TICK;
                        default: n_state = ST_IDLE;
                    endcase
                end
            end
            ST_SEND: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_ACK_CHK: n_state = ack_pre ? ST_ACK_RD : ST_ACK_IGN;
            ST_ACK_RD:  n_state = ST_ACK_CMP;
            ST_ACK_CMP: begin
                priority if (ack_hit) begin
                    if (out_free) begin
                        n_state = ST_IDLE;
                    end
                end else if (idx_last) begin
                    n_state = ST_ACK_IGN;
                end else begin
                    n_state = ST_ACK_RD;
                end
            end
            ST_ACK_IGN: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            ST_TICK: begin
                if (r_timer_on && tick_expire && (r_occ != '0)) begin
                    n_state = ST_RETX_RD;
                end else begin
                    n_state = ST_IDLE;
                end
            end
            ST_RETX_RD: n_state = ST_RETX_OUT;
            ST_RETX_OUT: begin
                if (out_free) begin
                    n_state = idx_last ? ST_IDLE : ST_RETX_RD;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_cur        = r_cur;
        n_head       = r_head;
        n_occ        = r_occ;
        n_idx        = r_idx;
        n_next_seq   = r_next_seq;
        n_base_seq   = r_base_seq;
        n_head_seq   = r_head_seq;
        n_timer_on   = r_timer_on;
        n_timer_left = r_timer_left;
        o_q_pop      = 1'b0;
        wr_en        = 1'b0;
        wr_addr      = wrap_add(r_head, r_occ);
        rd_en        = 1'b0;
        rd_addr      = wrap_add(r_head, CNT_W'(r_idx));
        emit         = 1'b0;
        e_action     = ACT_ACK_IGN;
        e_seq        = '0;
        e_len        = '0;
        e_slot       = '0;
        e_outs       = to_outs(r_occ);
        e_timer      = r_timer_on;
        e_last       = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_q_pop = !i_q_empty;
                n_cur   = i_q_entry;
            end
            ST_SEND: begin
                if (out_free) begin
                    emit = 1'b1;
                    if (occ_full) begin
                        e_action = ACT_FULL;
                    end else begin
                        wr_en      = 1'b1;
                        n_occ      = r_occ + CNT_W'(1);
                        n_next_seq = r_next_seq + SEQ_W'(r_cur.len);
                        if (r_occ == '0) begin
                            n_base_seq   = r_next_seq;
                            n_head_seq   = r_next_seq;
                            n_timer_on   = 1'b1;
                            n_timer_left = r_retry;
                        end else begin
                            n_base_seq = r_head_seq;
                        end
                        e_action = ACT_TX;
                        e_seq    = r_next_seq;
                        e_len    = r_cur.len;
                        e_slot   = to_slot(r_occ);
                        e_outs   = to_outs(r_occ + CNT_W'(1));
                        e_timer  = 1'b1;
                    end
                end
            end
            ST_ACK_CHK: begin
                n_idx = '0;
            end
            ST_ACK_RD: begin
                rd_en = 1'b1;
            end
            ST_ACK_CMP: begin
                if (ack_hit) begin
                    if (out_free) begin
                        emit       = 1'b1;
                        n_occ      = occ_keep;
                        n_head     = wrap_add(r_head, idx_plus[CNT_W-1:0]);
                        n_base_seq = r_rd_seq;
                        n_head_seq = r_cur.ack_no;
                        n_timer_on = r_timer_on && (occ_keep != '0);
                        e_action   = ACT_ACK_OK;
                        e_seq      = r_rd_seq;
                        e_slot     = to_slot(CNT_W'(r_idx));
                        e_outs     = to_outs(occ_keep);
                        e_timer    = r_timer_on && (occ_keep != '0);
                    end
                end else if (!idx_last) begin
                    n_idx = r_idx + IDX_W'(1);
                end
            end
            ST_ACK_IGN: begin
                emit = out_free;
            end
            ST_TICK: begin
                n_idx = '0;
                if (r_timer_on) begin
                    n_timer_left = tick_expire ? r_retry : r_timer_left - TICK_W'(1);
                end
            end
            ST_RETX_RD: begin
                rd_en = 1'b1;
            end
            ST_RETX_OUT: begin
                if (out_free) begin
                    emit     = 1'b1;
                    e_action = ACT_RETX;
                    e_seq    = r_rd_seq;
                    e_len    = r_rd_len;
                    e_slot   = to_slot(CNT_W'(r_idx));
                    e_last   = idx_last;
                    if (!idx_last) begin
                        n_idx = r_idx + IDX_W'(1);
                    end
                end
            end
            default: begin
                n_cur = r_cur;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_seq_mem[wr_addr] <= r_next_seq;
            r_len_mem[wr_addr] <= r_cur.len;
        end
        if (rd_en) begin
            r_rd_seq <= r_seq_mem[rd_addr];
            r_rd_len <= r_len_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        r_cur <= n_cur;
        if (emit) begin
            r_out_action <= e_action;
            r_out_seq    <= e_seq;
            r_out_len    <= e_len;
            r_out_slot   <= e_slot;
            r_out_outs   <= e_outs;
            r_out_timer  <= e_timer;
            r_out_last   <= e_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= ST_IDLE;
            r_head       <= '0;
            r_occ        <= '0;
            r_idx        <= '0;
            r_next_seq   <= '0;
            r_base_seq   <= '0;
            r_head_seq   <= '0;
            r_timer_on   <= 1'b0;
            r_timer_left <= '0;
            r_retry      <= RETRY_RESET;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_head       <= n_head;
            r_occ        <= n_occ;
            r_idx        <= n_idx;
            r_next_seq   <= n_next_seq;
            r_base_seq   <= n_base_seq;
            r_head_seq   <= n_head_seq;
            r_timer_on   <= n_timer_on;
            r_timer_left <= n_timer_left;
            if (i_cfg_we) begin
                r_retry <= i_cfg_wdata;
            end
            if (emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_action      = r_out_action;
    assign o_seq_no      = r_out_seq;
    assign o_seg_length  = r_out_len;
    assign o_slot        = r_out_slot;
    assign o_outstanding = r_out_outs;
    assign o_timer_on    = r_out_timer;
    assign o_last        = r_out_last;

`ifndef SYNTHESIS
    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occ <= Depth)
        else $error("window occupancy above depth");

    a_timer_tracks_occ: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_timer_on == (r_occ != '0))
        else $error("retransmit timer out of step with window");

    a_walk_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_RETX_OUT || r_state == ST_ACK_CMP) |-> (SUM_W'(r_idx) < SUM_W'(r_occ)))
        else $error("window walk beyond outstanding entries");

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !emit)
        else $error("result loaded over a pending transfer");
`endif

endmodule
